// File: hdl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the stack with statistics: operation and
// status codes, the stored entry layout and the fixed Q16.16 field widths.
// ----------------------------------------------------------------------------
package sws_pkg;

    // Width of one Q16.16 value
    localparam int Q_W = 32;
    // Width of the depth field in a result item
    localparam int DEPTH_FIELD_W = 7;
    // -1.0 in Q16.16, shown as the top value of an empty stack
    localparam logic signed [Q_W-1:0] NEG_ONE_Q16 = -32'sd65536;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One stack entry: the value and the running max/min up to and including it
    typedef struct packed {
        logic signed [Q_W-1:0] val;
        logic signed [Q_W-1:0] pmax;
        logic signed [Q_W-1:0] pmin;
    } entry_t;

endpackage

// File: hdl/sws_ifs.sv
// ----------------------------------------------------------------------------
// sws_ifs
// Valid/ready channels of the stack: the command channel (push or pop) and
// the result channel (status and statistics after each item).
// ----------------------------------------------------------------------------
interface sws_cmd_if
    import sws_pkg::*;
();
    logic                  valid;
    logic                  ready;
    op_t                   op;
    logic signed [Q_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sws_res_if
    import sws_pkg::*;
();
    logic                      valid;
    logic                      ready;
    status_t                   status;
    logic signed [Q_W-1:0]     top_value;
    logic [DEPTH_FIELD_W-1:0]  depth;
    logic                      is_empty;
    logic                      is_full;
    logic signed [Q_W-1:0]     maximum;
    logic signed [Q_W-1:0]     minimum;
    logic signed [Q_W-1:0]     average;

    modport source (
        output valid, output status, output top_value, output depth,
        output is_empty, output is_full, output maximum, output minimum,
        output average, input ready
    );
    modport sink (
        input valid, input status, input top_value, input depth,
        input is_empty, input is_full, input maximum, input minimum,
        input average, output ready
    );
endinterface

// File: hdl/sws_div.sv
// ----------------------------------------------------------------------------
// sws_div
// Bit-serial signed divider for the average: divides the running sum by the
// entry count, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sws_div
    import sws_pkg::*;
#(
    parameter int SUM_W = 39,
    parameter int CNT_W = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]         divisor,
    output logic                     done,
    output logic signed [Q_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsor_reg;
    logic [STEP_W-1:0]    step_reg;

    logic [CNT_W:0]       trial;
    logic                 fits;
    logic [CNT_W:0]       diff;
    logic [SUM_W-1:0]     quo_signed;

    // Trial subtraction of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dsor_reg});
    assign diff  = trial - {1'b0, dsor_reg};

    // Restore the sign; the magnitude of an average always fits 32 bits
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[Q_W-1:0];
    assign done       = done_reg;

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude bits shift out into the remainder, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[SUM_W-1];
            quo_reg  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

// File: hdl/stack_with_statistics.sv
// ----------------------------------------------------------------------------
// stack_with_statistics
// Bounded LIFO of signed Q16.16 values reporting top, depth, max, min and
// average after every push or pop.
// ----------------------------------------------------------------------------
// One item is taken at a time. Entries live in a single synchronous memory,
// each holding the value with the prefix maximum and minimum up to it, so
// max and min come straight from the top entry and a running sum gives the
// average. The top entry is also held in a register: a push builds its new
// entry from it in the accept cycle, a pop reads the entry below from the
// memory through S_READ. The average comes from a bit-serial divider that
// works through the SUM_W = 32 + clog2(DEPTH+1) bits of the running sum; an
// item that leaves the stack non-empty waits for the divider before the next
// item can be taken, while one that leaves it empty skips the divider. The
// result sits in an output register, so the next item is taken while it
// waits. A full push or an empty pop changes nothing and reports an error
// status. The memory needs no clearing: only entries written by a push are
// ever used. The depth field carries the low 7 bits of the entry count.
// ----------------------------------------------------------------------------
module stack_with_statistics
    import sws_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    sws_cmd_if.sink   cmd,
    sws_res_if.source res
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = Q_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    entry_t                  top_reg;
    status_t                 status_reg;
    logic signed [Q_W-1:0]   avg_reg;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic signed [Q_W-1:0]   out_top_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic                    out_empty_reg;
    logic                    out_full_reg;
    logic signed [Q_W-1:0]   out_max_reg;
    logic signed [Q_W-1:0]   out_min_reg;
    logic signed [Q_W-1:0]   out_avg_reg;

    entry_t                  mem [DEPTH];
    entry_t                  mem_rdata_reg;

    logic                    accept;
    logic                    is_push;
    logic                    full_now;
    logic                    empty_now;
    logic                    do_push;
    logic                    do_pop;
    entry_t                  entry_next;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        count_m2;
    logic [ADR_W-1:0]        mem_raddr;
    logic [ADR_W-1:0]        mem_waddr;
    logic                    div_start;
    logic                    div_done;
    logic signed [Q_W-1:0]   div_quotient;
    logic                    cnt_nonzero;
    logic                    load_out;

    // Handshake and decode
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_push   = (cmd.op == OP_PUSH);
    assign full_now  = (count_reg == CNT_W'(DEPTH));
    assign empty_now = (count_reg == '0);
    assign do_push   = accept && is_push && !full_now;
    assign do_pop    = accept && !is_push && !empty_now;
    assign cnt_nonzero = (count_reg != '0);

    // Result register loads once the previous item has gone
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    // New entry for a push: prefix max/min extend those of the current top
    always_comb
    begin
        entry_next.val  = cmd.value;
        entry_next.pmax = cmd.value;
        entry_next.pmin = cmd.value;
        if (!empty_now)
        begin
            if (top_reg.pmax > cmd.value)
                entry_next.pmax = top_reg.pmax;
            if (top_reg.pmin < cmd.value)
                entry_next.pmin = top_reg.pmin;
        end
    end

    // Running sum update
    always_comb
    begin
        if (is_push)
            sum_next = sum_reg + {{(SUM_W-Q_W){cmd.value[Q_W-1]}}, cmd.value};
        else
            sum_next = sum_reg - {{(SUM_W-Q_W){top_reg.val[Q_W-1]}}, top_reg.val};
    end

    // Memory addresses: a push writes at the count, a pop reads the new top
    assign count_m2  = count_reg - CNT_W'(2);
    assign mem_raddr = count_m2[ADR_W-1:0];
    assign mem_waddr = count_reg[ADR_W-1:0];

    // Entry store
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[mem_waddr] <= entry_next;
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign div_start = (state_reg == S_START) && cnt_nonzero;

    sws_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Control sequence, stack state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            sum_reg        <= '0;
            top_reg        <= '0;
            status_reg     <= ST_OK;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_count_reg  <= '0;
            out_empty_reg  <= 1'b1;
            out_full_reg   <= 1'b0;
            out_top_reg    <= NEG_ONE_Q16;
            out_max_reg    <= '0;
            out_min_reg    <= '0;
            out_avg_reg    <= '0;
        end
        else
        begin
            if (res.valid && res.ready && !load_out)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg  <= S_START;
                        status_reg <= ST_OK;
                        if (do_push)
                        begin
                            count_reg <= count_reg + 1'b1;
                            sum_reg   <= sum_next;
                            top_reg   <= entry_next;
                        end
                        else if (do_pop)
                        begin
                            count_reg <= count_reg - 1'b1;
                            sum_reg   <= sum_next;
                            if (count_reg != CNT_W'(1))
                                state_reg <= S_READ;
                        end
                        else if (is_push)
                            status_reg <= ST_FULL;
                        else
                            status_reg <= ST_EMPTY;
                    end
                end
                S_READ:
                begin
                    top_reg   <= mem_rdata_reg;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    if (cnt_nonzero)
                        state_reg <= S_DIV;
                    else
                    begin
                        avg_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_quotient;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_count_reg  <= count_reg;
                        out_empty_reg  <= !cnt_nonzero;
                        out_full_reg   <= full_now;
                        out_top_reg    <= cnt_nonzero ? top_reg.val : NEG_ONE_Q16;
                        out_max_reg    <= cnt_nonzero ? top_reg.pmax : '0;
                        out_min_reg    <= cnt_nonzero ? top_reg.pmin : '0;
                        out_avg_reg    <= avg_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result channel
    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.top_value = out_top_reg;
    assign res.depth     = DEPTH_FIELD_W'(out_count_reg);
    assign res.is_empty  = out_empty_reg;
    assign res.is_full   = out_full_reg;
    assign res.maximum   = out_max_reg;
    assign res.minimum   = out_min_reg;
    assign res.average   = out_avg_reg;

endmodule

// File: tb/tb_stack_with_statistics.sv
// ----------------------------------------------------------------------------
// tb_stack_with_statistics
// Self-checking bench for the Q16.16 stack with max/min/average reporting.
// A clocked driver offers push and pop items from a backlog, and a predictor
// works out the result of each accepted item. A clocked monitor compares
// every result field against the oldest pending prediction. Both sides idle
// at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_stack_with_statistics;
    import sws_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AFTER  = 150;   // results seen before the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 100;   // quiet cycles after the last result

    typedef struct {
        op_t                   op;
        logic signed [Q_W-1:0] value;
    } cmd_item_t;

    typedef struct {
        status_t                  status;
        logic signed [Q_W-1:0]    top_value;
        logic [DEPTH_FIELD_W-1:0] depth;
        logic                     is_empty;
        logic                     is_full;
        logic signed [Q_W-1:0]    maximum;
        logic signed [Q_W-1:0]    minimum;
        logic signed [Q_W-1:0]    average;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n;

    sws_cmd_if cmd_ch ();
    sws_res_if res_ch ();

    stack_with_statistics #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Bench copy of the stack
    logic signed [Q_W-1:0] stk_val  [DEPTH];
    logic signed [Q_W-1:0] stk_pmax [DEPTH];
    logic signed [Q_W-1:0] stk_pmin [DEPTH];
    int                    stk_count = 0;
    longint                stk_sum   = 0;

    cmd_item_t cmd_backlog [$];
    stats_t    stats_due   [$];

    int errors     = 0;
    int n_sent     = 0;
    int n_seen     = 0;
    int n_refused  = 0;
    int n_underrun = 0;
    int peak_depth = 0;
    int cycles     = 0;

    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    // Apply one item to the bench stack and return what the block should report
    function automatic stats_t stack_step(op_t op, logic signed [Q_W-1:0] v);
        stats_t s;
        int     t;
        s.status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (stk_count >= DEPTH)
            begin
                s.status = ST_FULL;
                n_refused++;
            end
            else
            begin
                stk_val[stk_count]  = v;
                stk_pmax[stk_count] = v;
                stk_pmin[stk_count] = v;
                if (stk_count > 0)
                begin
                    if (stk_pmax[stk_count-1] > v)
                        stk_pmax[stk_count] = stk_pmax[stk_count-1];
                    if (stk_pmin[stk_count-1] < v)
                        stk_pmin[stk_count] = stk_pmin[stk_count-1];
                end
                stk_count++;
                stk_sum += v;
            end
        end
        else if (stk_count == 0)
        begin
            s.status = ST_EMPTY;
            n_underrun++;
        end
        else
        begin
            stk_count--;
            stk_sum -= stk_val[stk_count];
        end

        if (stk_count > peak_depth)
            peak_depth = stk_count;

        if (stk_count > 0)
        begin
            t = stk_count - 1;
            s.top_value = stk_val[t];
            s.maximum   = stk_pmax[t];
            s.minimum   = stk_pmin[t];
            s.average   = Q_W'(stk_sum / stk_count);
        end
        else
        begin
            s.top_value = NEG_ONE_Q16;
            s.maximum   = '0;
            s.minimum   = '0;
            s.average   = '0;
        end
        s.depth    = DEPTH_FIELD_W'(stk_count);
        s.is_empty = (stk_count == 0);
        s.is_full  = (stk_count >= DEPTH);
        return s;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(4, 1);
        else
            return $urandom_range(60, 15);
    endfunction

    // Value mix: full-range, small, extremes, one-signed large
    function automatic logic signed [Q_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom;
        else if (r < 70)
            return $signed($urandom_range(32'h3FFFF, 0)) - 32'sd131072;
        else if (r < 85)
        begin
            case ($urandom_range(5))
                0:       return 32'sh7FFFFFFF;
                1:       return 32'sh80000000;
                2:       return '0;
                3:       return -32'sd1;
                4:       return NEG_ONE_Q16;
                default: return 32'sd1;
            endcase
        end
        else
            return {1'($urandom_range(1)), 31'($urandom)};
    endfunction

    task automatic add_cmd(op_t op, logic signed [Q_W-1:0] v);
        cmd_item_t c;
        c.op    = op;
        c.value = v;
        cmd_backlog.push_back(c);
    endtask

    task automatic check_field(string name, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: offer backlog items, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : drive_cmd
        cmd_item_t nxt;
        logic      offer;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            offer = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                stats_due.push_back(stack_step(cmd_ch.op, cmd_ch.value));
                n_sent++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_backlog.size() > 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    cmd_ch.op    <= nxt.op;
                    cmd_ch.value <= nxt.value;
                    offer    = 1'b1;
                    gap_left = pick_gap();
                end
            end
            cmd_ch.valid <= offer;
        end
    end

    // Monitor: check each taken result, stall at random, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : watch_res
        stats_t want;
        logic   rdy;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                n_seen++;
                if (stats_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got status %0d depth %0d",
                             $time, res_ch.status, res_ch.depth);
                    errors++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("status",    Q_W'(want.status),   Q_W'(res_ch.status));
                    check_field("top_value", want.top_value, res_ch.top_value);
                    check_field("depth",     Q_W'(want.depth),    Q_W'(res_ch.depth));
                    check_field("is_empty",  Q_W'(want.is_empty), Q_W'(res_ch.is_empty));
                    check_field("is_full",   Q_W'(want.is_full),  Q_W'(res_ch.is_full));
                    check_field("maximum",   want.maximum,   res_ch.maximum);
                    check_field("minimum",   want.minimum,   res_ch.minimum);
                    check_field("average",   want.average,   res_ch.average);
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && n_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if ($urandom_range(99) < 10)
                    stall_left = pick_gap();
            end
            res_ch.ready <= rdy;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, stats_due.size());
            $display("tb_stack_with_statistics NOT OK");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : run
        int n_rand;
        int seg_len;
        int push_pct;
        rst_n        = 1'b0;

        // Directed: empty pop with a value, extremes, negatives first, drain
        add_cmd(OP_POP,  32'sh7FFFFFFF);
        add_cmd(OP_PUSH, -32'sd196608);
        add_cmd(OP_PUSH, 32'sh80000000);
        add_cmd(OP_PUSH, -32'sd1);
        add_cmd(OP_PUSH, 32'sh7FFFFFFF);
        add_cmd(OP_PUSH, 32'sh7FFFFFFF);
        add_cmd(OP_PUSH, '0);
        add_cmd(OP_PUSH, NEG_ONE_Q16);
        add_cmd(OP_POP,  32'shFFFFFFFF);
        add_cmd(OP_POP,  32'sh80000000);
        add_cmd(OP_PUSH, 32'sd98304);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  '0);
        add_cmd(OP_POP,  32'sh55AA55AA);
        add_cmd(OP_PUSH, 32'sd1);
        add_cmd(OP_POP,  32'shAA55AA55);

        // Random: segments of push-heavy, balanced or pop-heavy traffic,
        // with one full fill past capacity and back down past empty
        n_rand = 0;
        while (n_rand < 400)
        begin
            if (n_rand >= 120 && n_rand < 200)
            begin
                repeat (DEPTH + 3) add_cmd(OP_PUSH, pick_value());
                repeat (DEPTH + 3) add_cmd(OP_POP, $urandom);
                n_rand += 2 * (DEPTH + 3);
            end
            else
            begin
                seg_len = $urandom_range(80, 10);
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 88;
                endcase
                repeat (seg_len)
                begin
                    if ($urandom_range(99) < push_pct)
                        add_cmd(OP_PUSH, pick_value());
                    else
                        add_cmd(OP_POP, $urandom);
                end
                n_rand += seg_len;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || cmd_ch.valid || stats_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d items sent, %0d results checked, deepest stack %0d of %0d",
                 n_sent, n_seen, peak_depth, DEPTH);
        $display("%0d pushes refused as full, %0d pops refused as empty, %0d errors",
                 n_refused, n_underrun, errors);
        if (errors == 0)
            $display("tb_stack_with_statistics OK");
        else
            $display("tb_stack_with_statistics NOT OK");
        $finish;
    end

endmodule
